// File: hw/rtl/hwga_pkg.sv
package hwga_pkg;

	// Field widths
	localparam int LETTER_W = 5;
	localparam int WEIGHT_W = 16;
	localparam int COL_W    = 12;
	localparam int ADJ_W    = 16;

	// Column sums saturate at all ones
	localparam int SUM_W = 21;

	// Hydrophilic fraction in Q0.12, at most 1.0, so 13 bits
	localparam int Q_BITS  = 12;
	localparam int FRAC_W  = 13;
	localparam int WIN     = 6;
	localparam int WSUM_W  = 16;
	localparam logic [WSUM_W-1:0] ROUND_HALF = 16'd2048;
	localparam logic [3:0] COUNT_MAX = 4'd6;

	// Restoring divider: one quotient bit per cycle
	localparam int DIV_STEPS = FRAC_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Letters A C D E F G H I K L M N P Q R S T V Y W; D E G K N P Q R S are hydrophilic
	localparam int NUM_LETTERS = 20;
	localparam logic [NUM_LETTERS-1:0] HYDRO_MASK = 20'h0F92C;

	// Configuration register map
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_FACTORS = 7;
	localparam int FACTOR_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_AMINO_ENABLE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_ZERO  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_SIX   = 4'd7;

	localparam logic signed [ADJ_W-1:0] FACTOR_RESET [NUM_FACTORS] = '{
		-16'sd1003, -16'sd3578, -16'sd2345, -16'sd1094, 16'sd20, 16'sd742, 16'sd425
	};

	// Controller to datapath commands
	typedef struct packed {
		logic acc;   // input item taken this cycle
		logic step;  // one divider iteration
		logic fin;   // close the column: window shift and result
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;  // output register can take a result this cycle
	} stat_t;

endpackage

// File: hw/rtl/hwga_ctrl.sv
module hwga_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              profile_start,
	input  logic              column_end,
	input  hwga_pkg::stat_t   stat,
	output logic              in_stall,
	output hwga_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam logic [hwga_pkg::DIV_CNT_W-1:0] LAST_STEP =
		hwga_pkg::DIV_CNT_W'(hwga_pkg::DIV_STEPS - 1);

	logic [1:0]                     state_q;
	logic [hwga_pkg::DIV_CNT_W-1:0] cnt_q;

	// Plain letter items flow while a column is being closed; boundary items wait
	assign in_stall = (state_q != ST_IDLE) && (profile_start || column_end);

	assign cmd.acc  = in_valid && !in_stall;
	assign cmd.step = (state_q == ST_DIV);
	assign cmd.fin  = (state_q == ST_FIN) && stat.out_free;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.acc && column_end) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (cnt_q == LAST_STEP) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/hwga_dp.sv
module hwga_dp #(
	parameter int MAX_COLUMNS = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  hwga_pkg::cmd_t                        cmd,
	output hwga_pkg::stat_t                       stat,
	input  logic                                  profile_start,
	input  logic [hwga_pkg::LETTER_W-1:0]         letter,
	input  logic [hwga_pkg::WEIGHT_W-1:0]         letter_weight,
	input  logic                                  column_end,
	input  logic                                  cfg_we,
	input  logic [hwga_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hwga_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [hwga_pkg::COL_W-1:0]            column_index,
	output logic signed [hwga_pkg::ADJ_W-1:0]     adjustment
);

	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int SW = hwga_pkg::SUM_W;
	localparam int FW = hwga_pkg::FRAC_W;
	localparam int NUM_W = SW + hwga_pkg::Q_BITS;

	// Configuration
	logic                                enable_q;
	logic signed [hwga_pkg::ADJ_W-1:0]   factor_q [hwga_pkg::NUM_FACTORS];
	logic [hwga_pkg::CFG_IDX_W-1:0]      cfg_off;

	// Column sums and column count
	logic [SW-1:0] total_q, hydro_q;
	logic [CW-1:0] cols_q;

	// Divider
	logic [SW-1:0] den_q, rem_q;
	logic [FW-1:0] lo_q;
	logic          zero_q;

	// Fraction window, oldest first
	logic [FW-1:0] win_q [hwga_pkg::WIN];

	// Output register
	logic                                out_valid_q;
	logic [hwga_pkg::COL_W-1:0]          column_index_q;
	logic signed [hwga_pkg::ADJ_W-1:0]   adjustment_q;

	logic [SW-1:0]   base_t, base_h, nxt_t, nxt_h;
	logic            letter_ok, is_hydro;
	logic [NUM_W:0]  num;
	logic [SW:0]     trial;
	logic            ge;
	logic [FW-1:0]   frac;
	logic [hwga_pkg::WSUM_W-1:0] wsum, wround;
	logic [3:0]      count;
	logic [hwga_pkg::FACTOR_IDX_W-1:0] fsel;
	logic            emit;
	logic [CW-1:0]   idx_full;
	logic [CW+hwga_pkg::COL_W-1:0] idx_ext;

	function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a,
			input logic [hwga_pkg::WEIGHT_W-1:0] b);
		logic [SW:0] s;
		s = {1'b0, a} + (SW+1)'(b);
		return s[SW] ? '1 : s[SW-1:0];
	endfunction

	// Accumulate this item on top of the running sums
	always_comb begin
		base_t    = profile_start ? '0 : total_q;
		base_h    = profile_start ? '0 : hydro_q;
		letter_ok = (letter < hwga_pkg::LETTER_W'(hwga_pkg::NUM_LETTERS));
		is_hydro  = letter_ok && hwga_pkg::HYDRO_MASK[letter];
		nxt_t     = letter_ok ? sat_add(base_t, letter_weight) : base_t;
		nxt_h     = is_hydro ? sat_add(base_h, letter_weight) : base_h;
		// hydro * 4096 + total / 2
		num       = {1'b0, nxt_h, {hwga_pkg::Q_BITS{1'b0}}} + (NUM_W+1)'(nxt_t >> 1);
	end

	// Divider iteration
	always_comb begin
		trial = {rem_q, lo_q[FW-1]};
		ge    = (trial >= {1'b0, den_q});
	end

	// Close the column: new fraction, rounded window count, result decision
	always_comb begin
		frac = zero_q ? '0 : lo_q;
		wsum = hwga_pkg::WSUM_W'(frac);
		for (int i = 1; i < hwga_pkg::WIN; i++) begin
			wsum = wsum + hwga_pkg::WSUM_W'(win_q[i]);
		end
		wround = wsum + hwga_pkg::ROUND_HALF;
		count  = wround[hwga_pkg::WSUM_W-1:hwga_pkg::Q_BITS];
		fsel   = (count > hwga_pkg::COUNT_MAX) ? hwga_pkg::FACTOR_IDX_W'(hwga_pkg::COUNT_MAX)
		                                        : count[hwga_pkg::FACTOR_IDX_W-1:0];
		emit     = enable_q && (cols_q >= CW'(5)) && (cols_q < CW'(MAX_COLUMNS));
		idx_full = cols_q - CW'(2);
		idx_ext  = {{hwga_pkg::COL_W{1'b0}}, idx_full};
		cfg_off  = cfg_index - hwga_pkg::CFG_FACTOR_ZERO;
	end

	assign stat.out_free = !out_valid_q || !out_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			for (int i = 0; i < hwga_pkg::NUM_FACTORS; i++) begin
				factor_q[i] <= hwga_pkg::FACTOR_RESET[i];
			end
		end else if (cfg_we) begin
			if (cfg_index == hwga_pkg::CFG_AMINO_ENABLE) begin
				enable_q <= cfg_data[0];
			end else if (cfg_index >= hwga_pkg::CFG_FACTOR_ZERO &&
			             cfg_index <= hwga_pkg::CFG_FACTOR_SIX) begin
				factor_q[cfg_off[hwga_pkg::FACTOR_IDX_W-1:0]] <= cfg_data;
			end
		end
	end

	// Sums, column count and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			hydro_q <= '0;
			cols_q  <= '0;
			for (int i = 0; i < hwga_pkg::WIN; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (cmd.acc) begin
				if (column_end) begin
					total_q <= '0;
					hydro_q <= '0;
				end else begin
					total_q <= nxt_t;
					hydro_q <= nxt_h;
				end
				if (profile_start) begin
					cols_q <= '0;
					for (int i = 0; i < hwga_pkg::WIN; i++) begin
						win_q[i] <= '0;
					end
				end
			end
			if (cmd.fin) begin
				for (int i = 0; i < hwga_pkg::WIN - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[hwga_pkg::WIN-1] <= frac;
				if (cols_q < CW'(MAX_COLUMNS)) begin
					cols_q <= cols_q + 1'b1;
				end
			end
		end
	end

	// Divider operands; quotient fits 13 bits, so the top of the numerator seeds the remainder
	always_ff @(posedge clk) begin
		if (cmd.acc && column_end) begin
			den_q  <= nxt_t;
			zero_q <= (nxt_t == '0);
			rem_q  <= SW'(num[NUM_W:FW]);
			lo_q   <= num[FW-1:0];
		end else if (cmd.step) begin
			rem_q <= ge ? SW'(trial - {1'b0, den_q}) : trial[SW-1:0];
			lo_q  <= {lo_q[FW-2:0], ge};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin && emit) begin
			column_index_q <= idx_ext[hwga_pkg::COL_W-1:0];
			adjustment_q   <= factor_q[fsel];
		end
	end

	assign out_valid    = out_valid_q;
	assign column_index = column_index_q;
	assign adjustment   = adjustment_q;

endmodule

// File: hw/rtl/hydrophilic_window_gap_adjust_unit.sv
// Hydrophilic window gap adjustment. Letter items are taken one per cycle. On the
// item that ends a column, the column's hydrophilic fraction is found by a restoring
// divider at one quotient bit per cycle, followed by a closing step that shifts the
// six-column window and registers the result once the output register is free.
// Plain letter items of the next column keep flowing meanwhile; an item carrying
// column_end or profile_start is held off until that column is closed, so short
// columns are paced by the divider rather than by the input.
// The result for column c-2 is produced when column c (5 <= c < MAX_COLUMNS) ends and the
// enable register is set; it waits in the output register while the next items run.
module hydrophilic_window_gap_adjust_unit #(
	parameter int MAX_COLUMNS = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  profile_start,
	input  logic [hwga_pkg::LETTER_W-1:0]         letter,
	input  logic [hwga_pkg::WEIGHT_W-1:0]         letter_weight,
	input  logic                                  column_end,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [hwga_pkg::COL_W-1:0]            column_index,
	output logic signed [hwga_pkg::ADJ_W-1:0]     adjustment,
	input  logic                                  cfg_we,
	input  logic [hwga_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hwga_pkg::CFG_DATA_W-1:0]       cfg_data
);

	hwga_pkg::cmd_t  cmd;
	hwga_pkg::stat_t stat;

	hwga_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.profile_start (profile_start),
		.column_end    (column_end),
		.stat          (stat),
		.in_stall      (in_stall),
		.cmd           (cmd)
	);

	hwga_dp #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.profile_start (profile_start),
		.letter        (letter),
		.letter_weight (letter_weight),
		.column_end    (column_end),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.column_index  (column_index),
		.adjustment    (adjustment)
	);

endmodule

// File: hw/rtl/hwga_chk.sv
module hwga_chk (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_stall,
	input logic                                  profile_start,
	input logic                                  column_end,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic [hwga_pkg::COL_W-1:0]            column_index,
	input logic signed [hwga_pkg::ADJ_W-1:0]     adjustment
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(column_index) && $stable(adjustment))
		else $error("stalled result changed");

	// Divider busy: no column end is taken in the cycle after one
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && column_end |=> !(in_valid && !in_stall && column_end))
		else $error("column end taken while divider busy");

	// No profile start is taken right after a column end
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && column_end |=> !(in_valid && !in_stall && profile_start))
		else $error("profile start taken while column open");

	// A fresh result follows its column end through the divider and closing states
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && column_end, 15))
		else $error("result without matching column end");

endmodule

bind hydrophilic_window_gap_adjust_unit hwga_chk u_chk (.*);

// File: dv/hydrophilic_window_gap_adjust_unit_tb.sv
`timescale 1ns / 100ps

module hydrophilic_window_gap_adjust_unit_tb;

	localparam int COLUMN_LIMIT  = 4096;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int CYCLE_LIMIT   = 1500000;
	localparam int ITEM_TARGET   = 1000;
	localparam int RESULT_TARGET = 30;
	localparam int PHASE_ITEMS   = 150;
	localparam int MAX_PHASES    = 40;

	// Letter codes, order A C D E F G H I K L M N P Q R S T V Y W
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_A = 5'd0;
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_C = 5'd1;
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_D = 5'd2;
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_E = 5'd3;
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_F = 5'd4;
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_G = 5'd5;
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_K = 5'd8;
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_N = 5'd11;
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_P = 5'd12;
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_Q = 5'd13;
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_R = 5'd14;
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_S = 5'd15;
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_W = 5'd19;
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_BAD_LO = 5'd20;
	localparam logic [hwga_pkg::LETTER_W-1:0] LTR_BAD_HI = 5'd31;

	localparam int unsigned SUM_SAT = (1 << hwga_pkg::SUM_W) - 1;
	localparam int unsigned ONE_Q12 = 1 << hwga_pkg::Q_BITS;

	typedef struct {
		logic                          start;
		logic [hwga_pkg::LETTER_W-1:0] letter;
		logic [hwga_pkg::WEIGHT_W-1:0] weight;
		logic                          col_end;
	} letter_item_t;

	typedef struct {
		logic [hwga_pkg::COL_W-1:0]        col;
		logic signed [hwga_pkg::ADJ_W-1:0] adj;
	} gap_adj_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic                                profile_start = 1'b0;
	logic [hwga_pkg::LETTER_W-1:0]       letter = '0;
	logic [hwga_pkg::WEIGHT_W-1:0]       letter_weight = '0;
	logic                                column_end = 1'b0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic [hwga_pkg::COL_W-1:0]          column_index;
	logic signed [hwga_pkg::ADJ_W-1:0]   adjustment;
	logic                                cfg_we = 1'b0;
	logic [hwga_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [hwga_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

	// Stimulus and scoreboard storage
	letter_item_t letter_pending[$];
	gap_adj_t     adj_expected[$];
	bit           in_taken = 1'b0;
	bit           tx_calm = 1'b0;
	bit           rx_calm = 1'b0;
	bit           hold_request = 1'b0;
	bit           phase_en = 1'b1;
	int           tx_gap = 0;
	int           rx_left = 0;
	int           mismatch_count = 0;
	int           items_made = 0;
	int           est_results = 0;
	int           cycle_count = 0;

	// Shadow of the block: registers and column state
	bit                                amino_en = 1'b1;
	logic signed [hwga_pkg::ADJ_W-1:0] factor_q12 [hwga_pkg::NUM_FACTORS] = '{
		-16'sd1003, -16'sd3578, -16'sd2345, -16'sd1094, 16'sd20, 16'sd742, 16'sd425
	};
	int unsigned tot_acc = 0;
	int unsigned hyd_acc = 0;
	int unsigned frac_hist [hwga_pkg::WIN] = '{default: 0};
	int unsigned cols_closed = 0;

	hydrophilic_window_gap_adjust_unit #(
		.MAX_COLUMNS(COLUMN_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.profile_start(profile_start),
		.letter(letter),
		.letter_weight(letter_weight),
		.column_end(column_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.column_index(column_index),
		.adjustment(adjustment),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit is_hydrophilic(input logic [hwga_pkg::LETTER_W-1:0] l);
		case (l)
			LTR_D, LTR_E, LTR_G, LTR_K, LTR_N, LTR_P, LTR_Q, LTR_R, LTR_S: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic int unsigned sat_sum(input int unsigned a, input int unsigned b);
		int unsigned s;
		s = a + b;
		return (s > SUM_SAT) ? SUM_SAT : s;
	endfunction

	// Q0.12 fraction, rounded half up; empty column gives zero
	function automatic int unsigned q12_fraction(input int unsigned hyd, input int unsigned tot);
		longint unsigned num;
		if (tot == 0)
			return 0;
		num = longint'(hyd) * ONE_Q12 + tot / 2;
		return int'(num / tot);
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic logic [hwga_pkg::WEIGHT_W-1:0] rand_weight();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return hwga_pkg::WEIGHT_W'($urandom_range(1, 15));
			3: return {1'b1, {(hwga_pkg::WEIGHT_W-1){1'b0}}};
			default: return hwga_pkg::WEIGHT_W'($urandom);
		endcase
	endfunction

	function automatic logic [hwga_pkg::CFG_DATA_W-1:0] rand_factor();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return hwga_pkg::CFG_DATA_W'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Advance the shadow state by one letter item; queue the adjustment it yields
	task automatic predict_adjust(input letter_item_t it);
		int unsigned wsum, cnt;
		gap_adj_t r;
		if (it.start) begin
			tot_acc = 0;
			hyd_acc = 0;
			frac_hist = '{default: 0};
			cols_closed = 0;
		end
		if (it.letter < hwga_pkg::NUM_LETTERS) begin
			tot_acc = sat_sum(tot_acc, it.weight);
			if (is_hydrophilic(it.letter))
				hyd_acc = sat_sum(hyd_acc, it.weight);
		end
		if (!it.col_end)
			return;
		for (int i = 0; i < hwga_pkg::WIN - 1; i++)
			frac_hist[i] = frac_hist[i+1];
		frac_hist[hwga_pkg::WIN-1] = q12_fraction(hyd_acc, tot_acc);
		tot_acc = 0;
		hyd_acc = 0;
		if (cols_closed >= 5 && cols_closed < COLUMN_LIMIT && amino_en) begin
			wsum = 0;
			for (int i = 0; i < hwga_pkg::WIN; i++)
				wsum += frac_hist[i];
			cnt = (wsum + ONE_Q12 / 2) >> hwga_pkg::Q_BITS;
			if (cnt > hwga_pkg::NUM_FACTORS - 1)
				cnt = hwga_pkg::NUM_FACTORS - 1;
			r.col = hwga_pkg::COL_W'(cols_closed - 2);
			r.adj = factor_q12[cnt];
			adj_expected.push_back(r);
		end
		if (cols_closed < COLUMN_LIMIT)
			cols_closed++;
	endtask

	// Register write; shadow copy follows at the same edge
	task automatic write_reg(input logic [hwga_pkg::CFG_IDX_W-1:0] idx,
			input logic [hwga_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		if (idx == hwga_pkg::CFG_AMINO_ENABLE)
			amino_en = val[0];
		else if (idx >= hwga_pkg::CFG_FACTOR_ZERO && idx <= hwga_pkg::CFG_FACTOR_SIX)
			factor_q12[idx - hwga_pkg::CFG_FACTOR_ZERO] = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic push_item(input bit st, input logic [hwga_pkg::LETTER_W-1:0] l,
			input logic [hwga_pkg::WEIGHT_W-1:0] w, input bit ce);
		letter_item_t it;
		it.start = st;
		it.letter = l;
		it.weight = w;
		it.col_end = ce;
		letter_pending.push_back(it);
		items_made++;
	endtask

	// One column; bias is the percent chance a hydrophilic weight survives
	task automatic make_column(input bit first, input int bias);
		int shape, len;
		logic [hwga_pkg::LETTER_W-1:0] l;
		logic [hwga_pkg::WEIGHT_W-1:0] w;
		shape = $urandom_range(0, 99);
		if (shape < 3)
			len = 40;
		else if (shape < 58)
			len = hwga_pkg::NUM_LETTERS;
		else
			len = $urandom_range(1, 8);
		for (int k = 0; k < len; k++) begin
			if (shape < 3) begin
				// heavy column, drives the sums into saturation
				l = (shape == 0) ? LTR_D :
					hwga_pkg::LETTER_W'($urandom_range(0, hwga_pkg::NUM_LETTERS - 1));
				w = '1;
			end else begin
				l = (len == hwga_pkg::NUM_LETTERS) ? hwga_pkg::LETTER_W'(k) :
					hwga_pkg::LETTER_W'($urandom_range(0, hwga_pkg::NUM_LETTERS - 1));
				if ($urandom_range(0, 99) < 4)
					l = hwga_pkg::LETTER_W'($urandom_range(LTR_BAD_LO, LTR_BAD_HI));
				w = rand_weight();
				if (is_hydrophilic(l) && $urandom_range(0, 99) >= bias)
					w = '0;
				else if (!is_hydrophilic(l) && $urandom_range(0, 99) < bias)
					w = '0;
			end
			push_item((first && k == 0) || $urandom_range(0, 199) == 0, l, w, k == len - 1);
		end
	endtask

	task automatic make_profile(input int ncols);
		int bias;
		case ($urandom_range(0, 4))
			0: bias = 0;
			1: bias = 100;
			default: bias = $urandom_range(0, 100);
		endcase
		for (int c = 0; c < ncols; c++) begin
			make_column(c == 0, bias);
			if (phase_en && c >= 5)
				est_results++;
		end
	endtask

	task automatic program_phase(input int phase, input bit en);
		logic [hwga_pkg::CFG_DATA_W-1:0] v;
		v = hwga_pkg::CFG_DATA_W'($urandom);
		v[0] = en;
		write_reg(hwga_pkg::CFG_AMINO_ENABLE, v);
		for (int k = 0; k < hwga_pkg::NUM_FACTORS; k++) begin
			case (phase)
				0: v = k[0] ? 16'h8000 : 16'h7FFF;
				2: v = k[0] ? 16'h7FFF : 16'h8000;
				default: v = rand_factor();
			endcase
			write_reg(hwga_pkg::CFG_IDX_W'(hwga_pkg::CFG_FACTOR_ZERO + k), v);
		end
		// unmapped index must leave everything alone
		if ($urandom_range(0, 2) == 0)
			write_reg(hwga_pkg::CFG_IDX_W'($urandom_range(hwga_pkg::CFG_FACTOR_SIX + 1,
				(1 << hwga_pkg::CFG_IDX_W) - 1)), hwga_pkg::CFG_DATA_W'($urandom));
	endtask

	// Sender empty, every adjustment back, then let the divider finish
	task automatic wait_drained();
		int waited;
		waited = 0;
		@(posedge clk);
		#1;
		while (letter_pending.size() != 0 || in_valid) begin
			@(posedge clk);
			#1;
		end
		while (adj_expected.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			#1;
			waited++;
		end
		if (adj_expected.size() != 0) begin
			report_mismatch($sformatf("%0d adjustments never arrived", adj_expected.size()));
			adj_expected.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sender: offers the next item after a random gap, holds it until taken
	always @(negedge clk) begin : drive_letters
		letter_item_t nxt;
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (tx_gap > 0) begin
				in_valid <= 1'b0;
				tx_gap--;
			end else if (letter_pending.size() != 0) begin
				nxt = letter_pending.pop_front();
				in_valid <= 1'b1;
				profile_start <= nxt.start;
				letter <= nxt.letter;
				letter_weight <= nxt.weight;
				column_end <= nxt.col_end;
				tx_gap = pick_gap(tx_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			rx_left = HOLD_CYCLES;
		end
		if (rx_left > 0) begin
			out_stall <= 1'b1;
			rx_left--;
		end else begin
			out_stall <= 1'b0;
			rx_left = pick_gap(rx_calm);
		end
	end

	// Check results against the oldest expectation, then predict accepted items
	always @(posedge clk) begin : watch_ports
		gap_adj_t e;
		letter_item_t it;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (adj_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected adjustment col %0d value %0d",
						column_index, adjustment));
				end else begin
					e = adj_expected.pop_front();
					if (column_index !== e.col)
						report_mismatch($sformatf("column_index %0d, expected %0d",
							column_index, e.col));
					if (adjustment !== e.adj)
						report_mismatch($sformatf("adjustment %0d for col %0d, expected %0d",
							adjustment, e.col, e.adj));
				end
			end
			if (in_valid && !in_stall) begin
				in_taken = 1'b1;
				it.start = profile_start;
				it.letter = letter;
				it.weight = letter_weight;
				it.col_end = column_end;
				predict_adjust(it);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		int phase, saved;
		bit en;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed items under reset register values
		push_item(1'b1, LTR_A, 16'hFFFF, 1'b1);      // only non-hydrophilic weight
		push_item(1'b0, LTR_D, 16'h0000, 1'b1);      // empty column
		push_item(1'b0, LTR_BAD_HI, 16'hFFFF, 1'b0); // letter out of range, ignored
		push_item(1'b0, LTR_E, 16'd100, 1'b1);
		push_item(1'b0, LTR_W, 16'hFFFF, 1'b1);
		push_item(1'b0, LTR_D, 16'hFFFF, 1'b1);
		push_item(1'b0, LTR_S, 16'd1, 1'b0);
		push_item(1'b0, LTR_A, 16'd2, 1'b1);         // first adjustment comes here
		push_item(1'b0, LTR_K, 16'h8000, 1'b1);
		push_item(1'b0, LTR_G, 16'd10, 1'b0);        // column spread over three items
		push_item(1'b0, LTR_F, 16'd30, 1'b0);
		push_item(1'b0, LTR_R, 16'd5, 1'b1);
		push_item(1'b0, LTR_BAD_LO, 16'h5555, 1'b1); // only an ignored letter
		push_item(1'b1, LTR_N, 16'd7, 1'b1);         // short profile, no adjustment
		push_item(1'b0, LTR_P, 16'd9, 1'b1);
		push_item(1'b0, LTR_C, 16'd3, 1'b1);
		push_item(1'b1, LTR_Q, 16'hFFFF, 1'b1);      // fully hydrophilic profile
		for (int c = 0; c < 5; c++)
			push_item(1'b0, LTR_R, 16'hFFFF, 1'b1);
		wait_drained();

		// Random phases, each with its own register setting
		phase = 0;
		items_made = 0;
		while ((items_made < ITEM_TARGET || est_results < RESULT_TARGET) &&
				phase < MAX_PHASES) begin
			if (phase == 1)
				en = 1'b0;
			else if (phase == 3)
				en = 1'b1;
			else
				en = ($urandom_range(0, 9) != 0);
			program_phase(phase, en);
			@(posedge clk);
			phase_en = en;
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				// receiver holds off while the sender keeps pushing
				tx_calm = 1'b1;
				hold_request = 1'b1;
			end
			saved = items_made;
			while (items_made - saved < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 15)
					make_profile($urandom_range(1, 5));
				else
					make_profile($urandom_range(6, 20));
			end
			wait_drained();
			phase++;
		end

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/hwga_pkg.sv
hw/rtl/hwga_ctrl.sv
hw/rtl/hwga_dp.sv
hw/rtl/hydrophilic_window_gap_adjust_unit.sv
hw/rtl/hwga_chk.sv
dv/hydrophilic_window_gap_adjust_unit_tb.sv
